>>> design/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg
// Constants, request codes, status codes and ring index helper for the
// double-ended queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CONTAINS   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // ring slot of the element at position pos (pos < DEPTH)
    function automatic idx_t slot_of(input idx_t head, input cnt_t pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage

`default_nettype wire

>>> design/dqs_if.sv
// ----------------------------------------------------------------------------
// dqs request and response channels
// Valid/ready channels carrying queue requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqs_req_if
    import dqs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic signed [31:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface dqs_rsp_if
    import dqs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic signed [31:0]  data;
    logic                found;
    logic signed [31:0]  front_value;
    logic signed [31:0]  back_value;
    logic [4:0]          count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output data, output found, output front_value,
                    output back_value, output count, output status, input ready);
    modport sink   (input valid, input data, input found, input front_value,
                    input back_value, input count, input status, output ready);
endinterface

`default_nettype wire

>>> design/dqs_ram.sv
// ----------------------------------------------------------------------------
// dqs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque of signed words held in a ring RAM, with search and remove.
// ----------------------------------------------------------------------------
// Flow: every request ends by fetching the front and back values (skipped with
//   the queue empty after) and waiting for the output; pops read their element,
//   contains and remove scan from the front until a match, and remove then moves
//   each later element down one slot. One request in flight; a result waiting
//   on the output holds the next one.
// Reset: queue empty, head at slot zero, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_with_search
    import dqs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dqs_req_if.sink     req,
    dqs_rsp_if.source   rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_FRONT = 3'd5;
    localparam logic [2:0] S_BACK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]          state_reg, state_next;
    idx_t                head_reg, head_next;
    cnt_t                cnt_reg, cnt_next;
    cnt_t                idx_reg, idx_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    value_t              value_reg, value_next;
    value_t              data_reg, data_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    value_t              front_reg, front_next;
    value_t              back_reg, back_next;
    logic                rsp_valid_reg, rsp_valid_next;
    value_t              out_data_reg, out_front_reg, out_back_reg;
    logic                out_found_reg;
    cnt_t                out_cnt_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                ram_we;
    idx_t                ram_waddr;
    value_t              ram_wdata;
    idx_t                ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    value_t              rd_val;

    logic                load_out;
    idx_t                head_dec;
    cnt_t                pos1;
    cnt_t                pos2;
    cnt_t                cnt_dec;

    dqs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val    = value_t'(ram_rdata);
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(head_reg - 1'b1);
    assign pos1      = CNT_W'(idx_reg + 1'b1);
    assign pos2      = CNT_W'(idx_reg + 2'd2);
    assign cnt_dec   = CNT_W'(cnt_reg - 1'b1);
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = value_reg;
        ram_raddr      = head_reg;
        load_out       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next   = req.func;
                    value_next  = req.value;
                    data_next   = '0;
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    idx_next    = '0;
                    state_next  = S_FETCH;
                    unique case (req.func)
                        FN_PUSH_FRONT, FN_PUSH_BACK:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = req.value;
                                cnt_next  = CNT_W'(cnt_reg + 1'b1);
                                if (req.func == FN_PUSH_FRONT)
                                begin
                                    ram_waddr = head_dec;
                                    head_next = head_dec;
                                end
                                else
                                begin
                                    ram_waddr = slot_of(head_reg, cnt_reg);
                                end
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = (req.func == FN_POP_FRONT) ? head_reg
                                             : slot_of(head_reg, cnt_dec);
                                state_next = S_POP;
                            end
                        end
                        FN_CONTAINS, FN_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                data_next = rd_val;
                cnt_next  = cnt_dec;
                if (func_reg == FN_POP_FRONT)
                begin
                    head_next = slot_of(head_reg, CNT_W'(1));
                end
                state_next = S_FETCH;
            end
            S_SRCH:
            begin
                if (rd_val == value_reg)
                begin
                    found_next = 1'b1;
                    data_next  = value_reg;
                    state_next = S_FETCH;
                    if (func_reg == FN_REMOVE)
                    begin
                        if (pos1 < cnt_reg)
                        begin
                            ram_raddr  = slot_of(head_reg, pos1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            cnt_next = cnt_dec;
                        end
                    end
                end
                else if (pos1 < cnt_reg)
                begin
                    idx_next  = pos1;
                    ram_raddr = slot_of(head_reg, pos1);
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_reg, idx_reg);
                ram_wdata = rd_val;
                if (pos2 < cnt_reg)
                begin
                    ram_raddr = slot_of(head_reg, pos2);
                    idx_next  = pos1;
                end
                else
                begin
                    cnt_next   = cnt_dec;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (cnt_reg == '0)
                begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = head_reg;
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                front_next = rd_val;
                ram_raddr  = slot_of(head_reg, cnt_dec);
                state_next = S_BACK;
            end
            S_BACK:
            begin
                back_next  = rd_val;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        func_reg   <= func_next;
        value_reg  <= value_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        front_reg  <= front_next;
        back_reg   <= back_next;
        if (load_out)
        begin
            out_data_reg   <= data_reg;
            out_found_reg  <= found_reg;
            out_front_reg  <= front_reg;
            out_back_reg   <= back_reg;
            out_cnt_reg    <= cnt_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.data        = out_data_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.back_value  = out_back_reg;
    assign rsp.count       = out_cnt_reg;
    assign rsp.status      = out_status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg == S_IDLE) && rsp_valid_reg)
        else $error("result load did not present result and return idle");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))
        || (CNT_W'(cnt_reg + 1'b1) == $past(cnt_reg)))
        else $error("element count changed by more than one");

    a_ram_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_IDLE) || (state_reg == S_SHIFT)))
        else $error("ring write outside push or shift");

endmodule

`default_nettype wire
